@@ rtl/asfa_pkg.sv @@
package asfa_pkg;

    // Reading and accumulator widths
    localparam int VALUE_BITS    = 24;
    localparam int SUM_BITS      = 32;
    localparam int CNT_BITS      = 8;
    localparam int OUT_BITS      = 24;
    localparam int NUM_SENSORS   = 4;
    localparam int IDX_BITS      = 2;
    localparam int RESULT_BITS   = 2 * NUM_SENSORS * OUT_BITS;
    localparam int DIV_STEP_BITS = $clog2(SUM_BITS);

    // Register reset value
    localparam logic [CNT_BITS-1:0] FPA_RESET = 8'd20;

    // ASCII digit bounds
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    // Parse phase codes: skip byte, first run, last run
    localparam logic [3:0] PH_SKIP     = 4'd0;
    localparam logic [3:0] PH_FIRST    = 4'd1;
    localparam logic [3:0] PH_LAST_RUN = 4'd8;

    // Frame-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } asfa_state_t;

    // Controls from the sequencer to the parser
    typedef struct packed {
        logic take;
        logic last;
        logic clear;
    } pctl_t;

endpackage

@@ rtl/asfa_parser.sv @@
module asfa_parser import asfa_pkg::*; (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  pctl_t                                   ctl,
    input  logic [7:0]                              data_byte,
    output logic [NUM_SENSORS-1:0][VALUE_BITS-1:0]  readings
);

    logic [3:0]                             phase_reg, phase_next;
    logic [VALUE_BITS-1:0]                  int_reg, int_next;
    logic [VALUE_BITS-1:0]                  frac_reg, frac_next;
    logic [NUM_SENSORS-1:0][VALUE_BITS-1:0] rd_reg, rd_next;

    logic                   is_digit;
    logic [3:0]             digit_val;
    logic [3:0]             run_cur;
    logic [3:0]             run_nxt;
    logic                   fin_we;
    logic [IDX_BITS-1:0]    fin_idx;
    logic [VALUE_BITS-1:0]  fin_int;
    logic [VALUE_BITS-1:0]  fin_frac;

    // acc * 10 + d, saturating
    function automatic logic [VALUE_BITS-1:0] digit_push(
        input logic [VALUE_BITS-1:0] acc,
        input logic [3:0]            d
    );
        logic [VALUE_BITS+3:0] t;
        t = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_BITS{1'b0}}, d};
        return (|t[VALUE_BITS+3:VALUE_BITS]) ? '1 : t[VALUE_BITS-1:0];
    endfunction

    // ip * 100 + fp, saturating
    function automatic logic [VALUE_BITS-1:0] finish_value(
        input logic [VALUE_BITS-1:0] ip,
        input logic [VALUE_BITS-1:0] fp
    );
        logic [VALUE_BITS+7:0] t;
        t = {2'b00, ip, 6'b000000} + {3'b000, ip, 5'b00000}
          + {6'b000000, ip, 2'b00} + {8'h00, fp};
        return (|t[VALUE_BITS+7:VALUE_BITS]) ? '1 : t[VALUE_BITS-1:0];
    endfunction

    assign is_digit  = (data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE);
    assign digit_val = 4'(data_byte - ASCII_ZERO);
    assign run_cur   = phase_reg - 4'd1;
    assign run_nxt   = phase_next - 4'd1;
    assign readings  = rd_reg;

    // Byte parse and reading completion
    always_comb begin
        phase_next = phase_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        rd_next    = rd_reg;
        fin_we     = 1'b0;
        fin_idx    = run_cur[2:1];
        fin_int    = int_reg;
        fin_frac   = frac_reg;
        if (ctl.clear) begin
            phase_next = PH_SKIP;
            int_next   = '0;
            frac_next  = '0;
            rd_next    = '0;
        end else if (ctl.take) begin
            if (phase_reg == PH_SKIP) begin
                phase_next = PH_FIRST;
            end else if (phase_reg <= PH_LAST_RUN) begin
                if (is_digit) begin
                    if (!run_cur[0]) begin
                        int_next = digit_push(int_reg, digit_val);
                    end else begin
                        frac_next = digit_push(frac_reg, digit_val);
                    end
                end else begin
                    // fraction run closed: reading complete
                    if (run_cur[0]) begin
                        fin_we    = 1'b1;
                        int_next  = '0;
                        frac_next = '0;
                    end
                    phase_next = phase_reg + 4'd1;
                end
            end
            // frame ends inside a run: close the open reading
            if (ctl.last && !fin_we && phase_next >= PH_FIRST
                    && phase_next <= PH_LAST_RUN) begin
                fin_we   = 1'b1;
                fin_idx  = run_nxt[2:1];
                fin_int  = int_next;
                fin_frac = frac_next;
            end
            if (fin_we) begin
                rd_next[fin_idx] = finish_value(fin_int, fin_frac);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            int_reg   <= '0;
            frac_reg  <= '0;
            rd_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            rd_reg    <= rd_next;
        end
    end

endmodule

@@ rtl/asfa_div.sv @@
module asfa_div import asfa_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SUM_BITS-1:0]   dividend,
    input  logic [CNT_BITS-1:0]   divisor,
    output logic                  done,
    output logic [OUT_BITS-1:0]   quotient
);

    logic                      busy_reg, busy_next;
    logic [DIV_STEP_BITS-1:0]  step_reg, step_next;
    logic [CNT_BITS-1:0]       rem_reg, rem_next;
    logic [SUM_BITS-1:0]       quo_reg, quo_next;
    logic [CNT_BITS-1:0]       dvs_reg, dvs_next;

    logic [CNT_BITS:0]     partial;
    logic [CNT_BITS:0]     diff;
    logic                  ge;

    // One restoring step per cycle, quotient bits shift in at the bottom
    assign partial  = {rem_reg, quo_reg[SUM_BITS-1]};
    assign diff     = partial - {1'b0, dvs_reg};
    assign ge       = partial >= {1'b0, dvs_reg};
    assign done     = busy_reg && (step_reg == '0);
    assign quotient = quo_next[OUT_BITS-1:0];

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = DIV_STEP_BITS'(SUM_BITS - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[CNT_BITS-1:0] : partial[CNT_BITS-1:0];
            quo_next  = {quo_reg[SUM_BITS-2:0], ge};
            step_next = step_reg - DIV_STEP_BITS'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

@@ rtl/ascii_sensor_frame_averager.sv @@
// ASCII sensor frame averager.
// Input stream (s_*): one received byte per request in s_tdata, s_tlast on
// the final byte of a frame. Output stream (m_*): one result per frame with
// the four readings and the four averages in hundredths; m_tuser is high when
// the frame closes an averaging period (averages are zero otherwise).
// Configuration (cfg_*): frames_per_average, always ready, reset value 20;
// write it only while the block is idle.
// Bytes that do not end a frame are taken at one per cycle while the block is
// idle. A frame-end byte starts a sequence: the sum update, one sensor per
// cycle through the shared adder; on a period end, the bit-serial divider that
// forms the four averages one after another; then the load of the output.
// s_tready is low during that sequence.
// The output register lets bytes of the next frame enter while a result
// waits; the next frame end holds in its load cycle until m_tready frees it.
// Reset (aresetn low, synchronous) clears the parser, sums, frame count and
// output valid, and sets frames_per_average to 20.
module ascii_sensor_frame_averager import asfa_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    // config write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CNT_BITS-1:0]     cfg_data,     // frames_per_average
    // byte input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,      // data_byte
    input  logic                    s_tlast,      // last_byte
    // result output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // temperature_now, humidity_now, soil_now, light_now,
    // temperature_mean, humidity_mean, soil_mean, light_mean
    output logic [RESULT_BITS-1:0]  m_tdata,
    output logic                    m_tuser       // mean_valid
);

    asfa_state_t state_reg, state_next;

    logic [CNT_BITS-1:0]                  fpa_reg;
    logic [CNT_BITS-1:0]                  count_reg, count_next;
    logic [IDX_BITS-1:0]                  idx_reg, idx_next;
    logic                                 period_reg, period_next;
    logic [NUM_SENSORS-1:0][SUM_BITS-1:0] sums_reg, sums_next;
    logic [NUM_SENSORS-1:0][OUT_BITS-1:0] mean_reg, mean_next;

    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [RESULT_BITS-1:0]               m_tdata_reg, m_tdata_next;
    logic                                 m_tuser_reg, m_tuser_next;

    pctl_t                                  pctl;
    logic [NUM_SENSORS-1:0][VALUE_BITS-1:0] readings;
    logic                                   div_start;
    logic                                   div_done;
    logic [OUT_BITS-1:0]                    div_quot;
    logic [SUM_BITS:0]                      acc_sum;
    logic                                   emit_ok;

    asfa_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (pctl),
        .data_byte (s_tdata),
        .readings  (readings)
    );

    asfa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sums_reg[idx_reg]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Shared saturating adder, one sensor per cycle
    assign acc_sum = {1'b0, sums_reg[idx_reg]}
                   + {{(SUM_BITS + 1 - VALUE_BITS){1'b0}}, readings[idx_reg]};
    assign emit_ok = !m_tvalid_reg || m_tready;

    // Frame-end sequencer
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        period_next   = period_reg;
        sums_next     = sums_reg;
        mean_next     = mean_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        pctl          = '0;
        div_start     = 1'b0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                pctl.take = s_tvalid;
                pctl.last = s_tlast;
                if (s_tvalid && s_tlast) begin
                    count_next = count_reg + 8'd1;
                    idx_next   = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                sums_next[idx_reg] = acc_sum[SUM_BITS] ? '1 : acc_sum[SUM_BITS-1:0];
                idx_next = idx_reg + IDX_BITS'(1);
                if (idx_reg == IDX_BITS'(NUM_SENSORS - 1)) begin
                    // count is at least one, so a zero register acts as one
                    period_next = count_reg >= fpa_reg;
                    idx_next    = '0;
                    state_next  = (count_reg >= fpa_reg) ? ST_DIV_START : ST_EMIT;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    mean_next[idx_reg] = div_quot;
                    if (idx_reg == IDX_BITS'(NUM_SENSORS - 1)) begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end else begin
                        idx_next   = idx_reg + IDX_BITS'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    for (int k = 0; k < NUM_SENSORS; k++) begin
                        m_tdata_next[k*OUT_BITS +: OUT_BITS] =
                            readings[k][OUT_BITS-1:0];
                        m_tdata_next[(NUM_SENSORS+k)*OUT_BITS +: OUT_BITS] =
                            period_reg ? mean_reg[k] : '0;
                    end
                    m_tuser_next  = period_reg;
                    m_tvalid_next = 1'b1;
                    pctl.clear    = 1'b1;
                    if (period_reg) begin
                        sums_next  = '0;
                        count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpa_reg      <= FPA_RESET;
            count_reg    <= '0;
            idx_reg      <= '0;
            period_reg   <= 1'b0;
            sums_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                fpa_reg <= cfg_data;
            end
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            period_reg   <= period_next;
            sums_reg     <= sums_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mean_reg    <= mean_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef NO_ASSERTIONS
    a_count_nonzero_in_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACC |-> count_reg != '0)
        else $error("frame count zero while summing");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_means_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tdata[RESULT_BITS-1:NUM_SENSORS*OUT_BITS] == '0)
        else $error("averages nonzero outside a period end");

    a_period_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && emit_ok && period_reg)
            |=> (count_reg == '0 && sums_reg == '0))
        else $error("period end did not clear sums");
`endif

endmodule
